// File: sv/multi_timer_bank_unit_macros.svh
// assertion macros used by the timer bank checker
`ifndef MULTI_TIMER_BANK_UNIT_MACROS_SVH
`define MULTI_TIMER_BANK_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MTB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MTB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mtb_pkg.sv
// types and constants of the timer bank
package mtb_pkg;

  localparam int OP_W        = 3;
  localparam int SLOT_W      = 4;
  localparam int CNT_W       = 32;
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 3'd0,
    OP_START  = 3'd1,
    OP_STOP   = 3'd2,
    OP_DELETE = 3'd3,
    OP_SET    = 3'd4,
    OP_READ   = 3'd5,
    OP_TICK   = 3'd6
  } op_t;

  localparam logic KIND_REPLY     = 1'b0;
  localparam logic KIND_EXPIRY    = 1'b1;
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_SLOT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_READ,
    ST_TICK,
    ST_REPLY
  } state_t;

  typedef struct packed {
    logic              kind;
    logic              status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  remaining;
    logic              last;
  } result_t;

endpackage

// File: sv/multi_timer_bank_unit.sv
// top level of the timer bank: command decode, slot memories and tick sweep
//
// A bank of NUM_TIMERS timers driven by command items (create, start, stop,
// delete, set count, read count, tick). Counts and reload values live in a
// synchronous memory with a registered read, the periodic flag in a
// second one; allocated and running flags are flip-flops cleared by reset,
// so no clearing pass is needed. One item is worked at a time and in_stall
// is high until its reply is handed to the output register. Create passes
// over each taken slot in turn. A tick sweeps the count memory through its
// single read port one slot per cycle, except while the result side stalls.
// Expiries come out in ascending slot order; each one is held back a step so
// the final one can carry out_last. A tick that expires nothing gives no
// result. At most 16 expiries per tick are reported, every timer is still
// updated.
module multi_timer_bank_unit import mtb_pkg::*; #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // command items
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_operation,
  input  logic [SLOT_W-1:0]   in_timer_index,
  input  logic                in_periodic,
  input  logic [CNT_W-1:0]    in_count_value,
  input  logic [CNT_W-1:0]    in_reload_value,
  // result items
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_kind,
  output logic                out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [CNT_W-1:0]    out_remaining,
  output logic                out_last
);

  localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int WIDE_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  // slot memories: {reload, remaining} and the periodic flag
  logic [2*CNT_W-1:0] cnt_mem [NUM_TIMERS];
  logic               per_mem [NUM_TIMERS];

  logic               mem_we;
  logic               mem_per_we;
  logic               mem_re;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_raddr;
  logic [2*CNT_W-1:0] mem_wdata;
  logic               mem_per_wdata;
  logic [2*CNT_W-1:0] rd_cnt_r;
  logic               rd_per_r;

  // control state
  state_t               state_r;
  state_t               state_nxt;
  logic [NUM_TIMERS-1:0] allocated_r;
  logic [NUM_TIMERS-1:0] running_r;
  logic [IDX_W-1:0]     scan_r;       // create search / tick read pointer
  logic                 scan_done_r;  // every slot has been read
  logic                 e_v_r;        // tick eval stage holds a slot
  logic [IDX_W-1:0]     e_idx_r;
  logic [RES_CNT_W-1:0] exp_n_r;      // expiries captured this tick
  logic                 p_v_r;        // expiry held back for the last flag
  logic [SLOT_W-1:0]    p_slot_r;

  // command payload
  logic             cmd_per_r;
  logic [CNT_W-1:0] cmd_cnt_r;
  logic [CNT_W-1:0] cmd_rel_r;
  result_t          rsp_r;

  // input decode
  op_t               in_op;
  logic              in_acc;
  logic              idx_ok;
  logic [WIDE_W-1:0] idx_wide;
  logic [IDX_W-1:0]  in_idx;

  assign in_op    = op_t'(in_operation);
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign idx_ok   = 32'(in_timer_index) < 32'(NUM_TIMERS);
  assign idx_wide = WIDE_W'(in_timer_index);
  assign in_idx   = idx_wide[IDX_W-1:0];

  // slot numbers as reported, masked to the field width
  logic [WIDE_W-1:0] scan_wide;
  logic [WIDE_W-1:0] e_wide;
  logic [SLOT_W-1:0] scan_slot;
  logic [SLOT_W-1:0] e_slot;

  assign scan_wide = WIDE_W'(scan_r);
  assign e_wide    = WIDE_W'(e_idx_r);
  assign scan_slot = scan_wide[SLOT_W-1:0];
  assign e_slot    = e_wide[SLOT_W-1:0];

  // create search: current slot free, or end of the bank
  logic scan_free;
  logic scan_last;

  assign scan_free = !allocated_r[scan_r];
  assign scan_last = (scan_r == LAST_IDX);

  // tick eval stage: one slot per cycle on the registered read data, unless the sweep stalls
  logic [CNT_W-1:0] e_rem;
  logic [CNT_W-1:0] e_rel;
  logic [CNT_W-1:0] e_dec;
  logic [CNT_W-1:0] e_new_rem;
  logic             e_act;
  logic             e_exp;
  logic             e_rep;
  logic             e_stop;

  assign e_rem  = rd_cnt_r[CNT_W-1:0];
  assign e_rel  = rd_cnt_r[2*CNT_W-1:CNT_W];
  assign e_dec  = e_rem - CNT_W'(1);
  // running timers with a zero count are left alone
  assign e_act  = e_v_r && running_r[e_idx_r] && (e_rem != '0);
  assign e_exp  = e_act && (e_dec == '0);
  assign e_rep  = e_exp && (exp_n_r < RES_CNT_W'(MAX_RESULTS));
  // one-shot stops; periodic reloads and stops on a zero reload
  assign e_stop = e_exp && (!rd_per_r || (e_rel == '0));
  assign e_new_rem = (e_exp && rd_per_r) ? e_rel : e_dec;

  // output stage hookup
  logic    out_free;
  logic    out_ld;
  result_t out_ld_data;

  logic tick_stall;
  logic tick_adv;
  logic tick_end;

  // a new expiry pushes the held one out, which needs room downstream
  assign tick_stall = e_rep && p_v_r && !out_free;
  assign tick_adv   = (state_r == ST_TICK) && !tick_stall;
  assign tick_end   = (state_r == ST_TICK) && scan_done_r && !e_v_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_TICK:   state_nxt = ST_TICK;
            OP_CREATE: state_nxt = ST_CREATE;
            OP_READ:   state_nxt = idx_ok ? ST_READ : ST_REPLY;
            default:   state_nxt = ST_REPLY;
          endcase
        end
      end
      ST_CREATE: begin
        if (scan_free || scan_last) begin
          state_nxt = ST_REPLY;
        end
      end
      ST_READ: state_nxt = ST_REPLY;
      ST_TICK: begin
        if (tick_end && (!p_v_r || out_free)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memory ports and result loads
  always_comb begin
    mem_we        = 1'b0;
    mem_per_we    = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = in_idx;
    mem_raddr     = in_idx;
    mem_wdata     = {in_reload_value, in_count_value};
    mem_per_wdata = cmd_per_r;
    out_ld        = 1'b0;
    out_ld_data   = rsp_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && idx_ok) begin
          // set keeps the timer type, read fetches the count
          mem_we = (in_op == OP_SET);
          mem_re = (in_op == OP_READ);
        end
      end
      ST_CREATE: begin
        mem_we     = scan_free;
        mem_per_we = scan_free;
        mem_waddr  = scan_r;
        mem_wdata  = {cmd_rel_r, cmd_cnt_r};
      end
      ST_TICK: begin
        mem_re    = tick_adv && !scan_done_r;
        mem_raddr = scan_r;
        mem_we    = tick_adv && e_act;
        mem_waddr = e_idx_r;
        mem_wdata = {e_rel, e_new_rem};
        out_ld_data.kind      = KIND_EXPIRY;
        out_ld_data.status    = STATUS_OK;
        out_ld_data.slot      = p_slot_r;
        out_ld_data.remaining = '0;
        out_ld_data.last      = tick_end;
        if (tick_adv && e_rep && p_v_r) begin
          out_ld = 1'b1;
        end else if (tick_end && p_v_r && out_free) begin
          out_ld = 1'b1;
        end
      end
      ST_REPLY: out_ld = out_free;
      default: ;
    endcase
  end

  // memories: synchronous write, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_per_we) begin
      per_mem[mem_waddr] <= mem_per_wdata;
    end
    if (mem_re) begin
      rd_cnt_r <= cnt_mem[mem_raddr];
      rd_per_r <= per_mem[mem_raddr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      allocated_r <= '0;
      running_r   <= '0;
      scan_r      <= '0;
      scan_done_r <= 1'b0;
      e_v_r       <= 1'b0;
      exp_n_r     <= '0;
      p_v_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            scan_r      <= '0;
            scan_done_r <= 1'b0;
            e_v_r       <= 1'b0;
            exp_n_r     <= '0;
            p_v_r       <= 1'b0;
            if (idx_ok) begin
              unique case (in_op)
                OP_START: begin
                  // a free slot is not started
                  if (allocated_r[in_idx]) begin
                    running_r[in_idx] <= 1'b1;
                  end
                end
                OP_STOP: running_r[in_idx] <= 1'b0;
                OP_DELETE: begin
                  running_r[in_idx]   <= 1'b0;
                  allocated_r[in_idx] <= 1'b0;
                end
                default: ;
              endcase
            end
          end
        end
        ST_CREATE: begin
          if (scan_free) begin
            allocated_r[scan_r] <= 1'b1;
            running_r[scan_r]   <= 1'b0;
          end else if (!scan_last) begin
            scan_r <= scan_r + IDX_W'(1);
          end
        end
        ST_TICK: begin
          if (tick_adv) begin
            if (e_stop) begin
              running_r[e_idx_r] <= 1'b0;
            end
            if (e_rep) begin
              p_v_r   <= 1'b1;
              exp_n_r <= exp_n_r + RES_CNT_W'(1);
            end
            if (!scan_done_r) begin
              e_v_r <= 1'b1;
              if (scan_last) begin
                scan_done_r <= 1'b1;
              end else begin
                scan_r <= scan_r + IDX_W'(1);
              end
            end else begin
              e_v_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_per_r       <= in_periodic;
          cmd_cnt_r       <= in_count_value;
          cmd_rel_r       <= in_reload_value;
          rsp_r.kind      <= KIND_REPLY;
          rsp_r.status    <= STATUS_OK;
          rsp_r.slot      <= '0;
          rsp_r.remaining <= '0;
          rsp_r.last      <= 1'b1;
        end
      end
      ST_CREATE: begin
        if (scan_free) begin
          rsp_r.slot <= scan_slot;
        end else if (scan_last) begin
          rsp_r.status <= STATUS_NO_SLOT;
        end
      end
      ST_READ: rsp_r.remaining <= rd_cnt_r[CNT_W-1:0];
      ST_TICK: begin
        if (tick_adv) begin
          if (!scan_done_r) begin
            e_idx_r <= scan_r;
          end
          if (e_rep) begin
            p_slot_r <= e_slot;
          end
        end
      end
      default: ;
    endcase
  end

  mtb_out_stage u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .ld            (out_ld),
    .ld_data       (out_ld_data),
    .free          (out_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_status    (out_status),
    .out_slot      (out_slot),
    .out_remaining (out_remaining),
    .out_last      (out_last)
  );

endmodule

// File: sv/mtb_out_stage.sv
// output register of the result channel
module mtb_out_stage import mtb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld,
  input  result_t             ld_data,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_kind,
  output logic                out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [CNT_W-1:0]    out_remaining,
  output logic                out_last
);

  logic    out_valid_r;
  result_t data_r;

  // room when empty or the held item leaves this cycle
  assign free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      data_r <= ld_data;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = data_r.kind;
  assign out_status    = data_r.status;
  assign out_slot      = data_r.slot;
  assign out_remaining = data_r.remaining;
  assign out_last      = data_r.last;

endmodule

// File: sv/mtb_checker.sv
// port-level checks of the timer bank, bound to the top level
`include "multi_timer_bank_unit_macros.svh"

module mtb_checker import mtb_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_kind,
  input logic              out_status,
  input logic [SLOT_W-1:0] out_slot,
  input logic [CNT_W-1:0]  out_remaining,
  input logic              out_last
);

  // result classes seen on the port
  logic in_take;
  logic reply_v;
  logic fail_v;
  logic fail_ok;
  logic expiry_v;
  logic expiry_ok;
  logic out_hold;

  assign in_take   = in_valid && !in_stall;
  assign reply_v   = out_valid && (out_kind == KIND_REPLY);
  assign fail_v    = out_valid && (out_status == STATUS_NO_SLOT);
  assign fail_ok   = (out_kind == KIND_REPLY) && (out_slot == '0);
  assign expiry_v  = out_valid && (out_kind == KIND_EXPIRY);
  assign expiry_ok = (out_remaining == '0) && (out_status == STATUS_OK);
  assign out_hold  = out_valid && out_stall;

  // one item at a time: a taken command blocks the next cycle
  `MTB_ASSERT_NEXT(a_busy_after_accept, in_take, in_stall, "accepted item did not block input")

  // a reply is a single item and carries last
  `MTB_ASSERT_SAME(a_reply_is_last, reply_v, out_last, "reply without last")

  // failed create reports slot zero
  `MTB_ASSERT_SAME(a_fail_is_create, fail_v, fail_ok, "bad failure result")

  // expiries carry no count and no failure
  `MTB_ASSERT_SAME(a_expiry_clean, expiry_v, expiry_ok, "bad expiry result")

  // a stalled result stays offered
  `MTB_ASSERT_NEXT(a_out_hold, out_hold, out_valid, "stalled result dropped")

endmodule

bind multi_timer_bank_unit mtb_checker u_mtb_checker (.*);

// File: dv/tb_multi_timer_bank_unit.sv
// self-checking testbench of the timer bank: command stream, expiry prediction, result checks
module tb_multi_timer_bank_unit import mtb_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS   = 16;
  localparam int HOLD_CYCLES = 300;      // long receiver hold-off that backs up the bank
  localparam int DRAIN_WAIT  = 4 * NUM_SLOTS;
  localparam int CYCLE_LIMIT = 500000;   // far above the slowest legal run

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // command side, driven at the rising edge
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_operation    = '0;
  logic [SLOT_W-1:0] in_timer_index  = '0;
  logic              in_periodic     = 1'b0;
  logic [CNT_W-1:0]  in_count_value  = '0;
  logic [CNT_W-1:0]  in_reload_value = '0;

  // result side
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_kind;
  logic              out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [CNT_W-1:0]  out_remaining;
  logic              out_last;

  // shadow copy of the timer bank, kept by the predictor
  bit               tmr_alloc   [NUM_SLOTS];
  bit               tmr_active  [NUM_SLOTS];
  bit               tmr_periodic[NUM_SLOTS];
  bit               tmr_written [NUM_SLOTS];  // count stored at least once, so a read is legal
  logic [CNT_W-1:0] tmr_count   [NUM_SLOTS];
  logic [CNT_W-1:0] tmr_reload  [NUM_SLOTS];

  result_t pending_results[$];  // replies and expiries not yet seen on the output

  // idling knobs, percent of cycles
  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;
  int hold_left     = 0;

  int fail_count  = 0;
  int cycle_count = 0;

  multi_timer_bank_unit #(
    .NUM_TIMERS(NUM_SLOTS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_timer_index (in_timer_index),
    .in_periodic    (in_periodic),
    .in_count_value (in_count_value),
    .in_reload_value(in_reload_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_remaining  (out_remaining),
    .out_last       (out_last)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // works out what one accepted command gives and updates the shadow bank
  function automatic void predict_timer_bank(op_t op, logic [SLOT_W-1:0] idx, logic per,
                                             logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] rel);
    result_t r;
    result_t fired[$];
    bit      placed;
    r        = '0;
    r.kind   = KIND_REPLY;
    r.status = STATUS_OK;
    r.last   = 1'b1;
    placed   = 1'b0;
    case (op)
      OP_TICK: begin
        // sweep in slot order; a running timer parked at zero is left alone
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!tmr_active[i] || tmr_count[i] == '0) continue;
          tmr_count[i] = tmr_count[i] - 1;
          if (tmr_count[i] != '0) continue;
          if (tmr_periodic[i]) begin
            tmr_count[i] = tmr_reload[i];
            if (tmr_reload[i] == '0) tmr_active[i] = 1'b0;
          end else begin
            tmr_active[i] = 1'b0;
          end
          if (fired.size() < MAX_RESULTS) begin
            r        = '0;
            r.kind   = KIND_EXPIRY;
            r.status = STATUS_OK;
            r.slot   = SLOT_W'(i);
            fired.push_back(r);
          end
        end
        // nothing expired means nothing comes out
        if (fired.size() > 0) begin
          fired[fired.size() - 1].last = 1'b1;
          foreach (fired[k]) pending_results.push_back(fired[k]);
        end
      end
      OP_CREATE: begin
        // lowest free slot wins; a full bank reports failure and changes nothing
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (!placed && !tmr_alloc[i]) begin
            placed          = 1'b1;
            tmr_alloc[i]    = 1'b1;
            tmr_active[i]   = 1'b0;
            tmr_periodic[i] = per;
            tmr_count[i]    = cnt;
            tmr_reload[i]   = rel;
            tmr_written[i]  = 1'b1;
            r.slot          = SLOT_W'(i);
          end
        end
        if (!placed) r.status = STATUS_NO_SLOT;
        pending_results.push_back(r);
      end
      OP_START: begin
        // a free slot cannot be started
        if (tmr_alloc[idx]) tmr_active[idx] = 1'b1;
        pending_results.push_back(r);
      end
      OP_STOP: begin
        tmr_active[idx] = 1'b0;
        pending_results.push_back(r);
      end
      OP_DELETE: begin
        tmr_active[idx] = 1'b0;
        tmr_alloc[idx]  = 1'b0;
        pending_results.push_back(r);
      end
      OP_SET: begin
        // a running timer keeps running from the new count
        tmr_count[idx]   = cnt;
        tmr_reload[idx]  = rel;
        tmr_written[idx] = 1'b1;
        pending_results.push_back(r);
      end
      OP_READ: begin
        r.remaining = tmr_count[idx];
        pending_results.push_back(r);
      end
      default: begin
        pending_results.push_back(r);
      end
    endcase
  endfunction

  // offers one command, waits for the handshake, then predicts it;
  // valid stays high afterwards so back-to-back items need no second assignment
  task automatic send_cmd(op_t op, logic [SLOT_W-1:0] idx, logic per,
                          logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] rel);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_timer_index  <= idx;
    in_periodic     <= per;
    in_count_value  <= cnt;
    in_reload_value <= rel;
    do @(posedge clk); while (in_stall);
    predict_timer_bank(op, idx, per, cnt, rel);
  endtask

  // mostly short counts so timers really expire, now and then anything at all
  function automatic logic [CNT_W-1:0] pick_count();
    int roll;
    roll = $urandom_range(99);
    if (roll < 80) return CNT_W'($urandom_range(0, 6));
    if (roll < 90) return CNT_W'($urandom_range(7, 40));
    return CNT_W'($urandom);
  endfunction

  // usually an allocated slot, sometimes any slot as noise
  function automatic logic [SLOT_W-1:0] pick_slot();
    logic [SLOT_W-1:0] live[$];
    for (int i = 0; i < NUM_SLOTS; i++) if (tmr_alloc[i]) live.push_back(SLOT_W'(i));
    if (live.size() == 0 || $urandom_range(9) < 2) return SLOT_W'($urandom_range(NUM_SLOTS - 1));
    return live[$urandom_range(live.size() - 1)];
  endfunction

  // one random command; reads only go to slots whose count was ever stored
  task automatic send_random_item();
    op_t               op;
    logic [SLOT_W-1:0] idx;
    logic [SLOT_W-1:0] readable[$];
    int                roll;
    roll = $urandom_range(99);
    idx  = pick_slot();
    if      (roll < 12) op = OP_CREATE;
    else if (roll < 27) op = OP_START;
    else if (roll < 33) op = OP_STOP;
    else if (roll < 39) op = OP_DELETE;
    else if (roll < 49) op = OP_SET;
    else if (roll < 61) op = OP_READ;
    else                op = OP_TICK;
    if (op == OP_READ) begin
      for (int i = 0; i < NUM_SLOTS; i++) if (tmr_written[i]) readable.push_back(SLOT_W'(i));
      if (readable.size() == 0) op = OP_TICK;
      else idx = readable[$urandom_range(readable.size() - 1)];
    end
    send_cmd(op, idx, 1'($urandom), pick_count(), pick_count());
  endtask

  // every command, field extremes and the corner cases of counting
  task automatic test_directed_commands();
    send_cmd(OP_CREATE, 4'd0,  1'b1, '1, '1);         // periodic, full-scale count and reload
    send_cmd(OP_CREATE, 4'd0,  1'b0, 32'd1, 32'd0);   // one-shot, expires on first tick
    send_cmd(OP_CREATE, 4'd0,  1'b1, 32'd2, 32'd0);   // periodic with zero reload stops
    send_cmd(OP_CREATE, 4'd0,  1'b0, 32'd0, 32'd0);   // zero count: runs but never expires
    send_cmd(OP_START,  4'd0,  1'b0, '0, '0);
    send_cmd(OP_START,  4'd1,  1'b0, '0, '0);
    send_cmd(OP_START,  4'd1,  1'b0, '0, '0);         // already running
    send_cmd(OP_START,  4'd2,  1'b0, '0, '0);
    send_cmd(OP_START,  4'd3,  1'b0, '0, '0);
    send_cmd(OP_START,  4'd15, 1'b1, '1, '1);         // free slot, ignored
    send_cmd(OP_TICK,   4'd0,  1'b0, '0, '0);
    send_cmd(OP_TICK,   4'd0,  1'b0, '0, '0);
    send_cmd(OP_READ,   4'd2,  1'b0, '0, '0);
    send_cmd(OP_READ,   4'd3,  1'b0, '0, '0);
    send_cmd(OP_STOP,   4'd3,  1'b0, '0, '0);
    send_cmd(OP_STOP,   4'd3,  1'b0, '0, '0);         // already stopped
    send_cmd(OP_SET,    4'd0,  1'b0, 32'd1, 32'd2);   // new count on a running timer
    send_cmd(OP_TICK,   4'd0,  1'b0, '0, '0);
    send_cmd(OP_READ,   4'd0,  1'b0, '0, '0);
    send_cmd(OP_DELETE, 4'd1,  1'b0, '0, '0);
    send_cmd(OP_CREATE, 4'd0,  1'b0, 32'd5, '1);      // reuses the freed slot
    send_cmd(OP_READ,   4'd1,  1'b0, '0, '0);
    send_cmd(OP_SET,    4'd15, 1'b0, '1, 32'd0);      // slot never created
    send_cmd(OP_READ,   4'd15, 1'b0, '0, '0);
  endtask

  // fill every slot, overflow the bank, then expire all sixteen on one tick
  task automatic test_full_bank();
    for (int i = 0; i < NUM_SLOTS; i++) send_cmd(OP_DELETE, SLOT_W'(i), 1'b0, '0, '0);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      send_cmd(OP_CREATE, 4'd0, 1'($urandom), 32'd1, CNT_W'($urandom_range(0, 3)));
    end
    send_cmd(OP_CREATE, 4'd0, 1'b1, 32'd3, 32'd3);    // no free slot
    for (int i = 0; i < NUM_SLOTS; i++) send_cmd(OP_START, SLOT_W'(i), 1'b0, '0, '0);
    repeat (4) send_cmd(OP_TICK, 4'd0, 1'b0, '0, '0);
    for (int i = 0; i < 4; i++) send_cmd(OP_DELETE, SLOT_W'($urandom_range(NUM_SLOTS - 1)),
                                         1'b0, '0, '0);
  endtask

  // random traffic under one idling setting
  task automatic test_random_traffic(int n_items, int idle_pct, int stall_p);
    send_idle_pct = idle_pct;
    stall_pct     = stall_p;
    repeat (n_items) send_random_item();
  endtask

  // the receiver holds off while commands keep coming, so the bank backs up
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b1;
    repeat (15) send_random_item();
  endtask

  // receiver: random stalls, or a long hold-off when asked for one
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic compare_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // every accepted result is matched against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: kind %0d slot %0d", out_kind, out_slot);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("kind",      CNT_W'(want.kind),   CNT_W'(out_kind));
        compare_field("status",    CNT_W'(want.status), CNT_W'(out_status));
        compare_field("slot",      CNT_W'(want.slot),   CNT_W'(out_slot));
        compare_field("remaining", want.remaining,      out_remaining);
        compare_field("last",      CNT_W'(want.last),   CNT_W'(out_last));
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_commands();
    test_full_bank();
    test_random_traffic(75, 0, 0);
    test_random_traffic(75, 67, 0);
    test_random_traffic(75, 0, 67);
    test_random_traffic(75, 18, 18);
    test_output_backpressure();

    // drain: everything predicted must come out, then watch for strays
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+sv
sv/mtb_pkg.sv
sv/mtb_out_stage.sv
sv/multi_timer_bank_unit.sv
sv/mtb_checker.sv
dv/tb_multi_timer_bank_unit.sv
